FILE: src/fgsr_pkg.sv
// Shared types, constants and the 5x8 font table of the glyph rasterizer.
`default_nettype none

package fgsr_pkg;

   // Glyph geometry
   localparam int GLYPH_W       = 5;
   localparam int GLYPH_H       = 8;
   localparam int GLYPH_BITS    = GLYPH_W * GLYPH_H;
   localparam int GLYPH_COUNT   = 62;
   localparam int GLYPH_IDX_W   = 6;
   localparam int COL_W         = 3;
   localparam int ROW_W         = 3;

   // Field widths
   localparam int CHAR_W        = 8;
   localparam int ORIGIN_X_W    = 7;
   localparam int ORIGIN_Y_W    = 5;
   localparam int PIXEL_INDEX_W = 8;
   localparam int COLOR_W       = 24;
   localparam int POS_W         = 8;

   localparam logic [COLOR_W-1:0] COLOR_RESET = 24'hFF_FFFF;

   // Character ranges
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_LO = 8'h30;   // '0'
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_HI = 8'h39;   // '9'
   localparam logic [CHAR_W-1:0] CHAR_UPPER_LO = 8'h41;   // 'A'
   localparam logic [CHAR_W-1:0] CHAR_UPPER_HI = 8'h5A;   // 'Z'
   localparam logic [CHAR_W-1:0] CHAR_LOWER_LO = 8'h61;   // 'a'
   localparam logic [CHAR_W-1:0] CHAR_LOWER_HI = 8'h7A;   // 'z'
   localparam int               UPPER_BASE    = 10;
   localparam int               LOWER_BASE    = 36;

   // Sequencer commands to the datapath
   typedef struct packed {
      logic load;       // capture the incoming word
      logic step;       // emit the current cell and advance
      logic emit_err;   // emit the error word
   } fgsr_cmd_type;

   // Datapath status to the sequencer
   typedef struct packed {
      logic last_cell;  // current cell is the final glyph cell
      logic unsup;      // captured character has no glyph
      logic out_free;   // output register can take a word this cycle
   } fgsr_status_type;

   typedef struct packed {
      logic                   ok;
      logic [GLYPH_IDX_W-1:0] idx;
   } glyph_sel_type;

   // Map a character code to its glyph number
   function automatic glyph_sel_type glyph_of(input logic [CHAR_W-1:0] ch);
      glyph_sel_type sel;
      sel.ok  = 1'b0;
      sel.idx = '0;
      if (ch >= CHAR_DIGIT_LO && ch <= CHAR_DIGIT_HI) begin
         sel.ok  = 1'b1;
         sel.idx = GLYPH_IDX_W'(ch - CHAR_DIGIT_LO);
      end else if (ch >= CHAR_UPPER_LO && ch <= CHAR_UPPER_HI) begin
         sel.ok  = 1'b1;
         sel.idx = GLYPH_IDX_W'(ch - CHAR_UPPER_LO) + GLYPH_IDX_W'(UPPER_BASE);
      end else if (ch >= CHAR_LOWER_LO && ch <= CHAR_LOWER_HI) begin
         sel.ok  = 1'b1;
         sel.idx = GLYPH_IDX_W'(ch - CHAR_LOWER_LO) + GLYPH_IDX_W'(LOWER_BASE);
      end
      return sel;
   endfunction

   // Font table: one glyph per entry, top row first, leftmost column in the MSB
   function automatic logic [GLYPH_BITS-1:0] font_glyph(input logic [GLYPH_IDX_W-1:0] g);
      logic [GLYPH_BITS-1:0] bits;
      unique case (g)
         6'd0:  bits = {5'h0E, 5'h11, 5'h11, 5'h15, 5'h15, 5'h11, 5'h11, 5'h0E};
         6'd1:  bits = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
         6'd2:  bits = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
         6'd3:  bits = {5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h01, 5'h11, 5'h0E};
         6'd4:  bits = {5'h10, 5'h10, 5'h12, 5'h1F, 5'h02, 5'h02, 5'h02, 5'h02};
         6'd5:  bits = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h01, 5'h11, 5'h0E};
         6'd6:  bits = {5'h0E, 5'h11, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h0E};
         6'd7:  bits = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h04, 5'h08, 5'h08, 5'h08};
         6'd8:  bits = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};
         6'd9:  bits = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h11, 5'h0E};
         6'd10: bits = {5'h04, 5'h0A, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
         6'd11: bits = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E};
         6'd12: bits = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
         6'd13: bits = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
         6'd14: bits = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10, 5'h1F};
         6'd15: bits = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10, 5'h10};
         6'd16: bits = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h11, 5'h0E};
         6'd17: bits = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11, 5'h11};
         6'd18: bits = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
         6'd19: bits = {5'h1F, 5'h01, 5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h0E};
         6'd20: bits = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11, 5'h11};
         6'd21: bits = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
         6'd22: bits = {5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11};
         6'd23: bits = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11, 5'h11};
         6'd24: bits = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
         6'd25: bits = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10, 5'h10};
         6'd26: bits = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
         6'd27: bits = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h11};
         6'd28: bits = {5'h0E, 5'h11, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h11, 5'h0E};
         6'd29: bits = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
         6'd30: bits = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
         6'd31: bits = {5'h11, 5'h11, 5'h11, 5'h0A, 5'h0A, 5'h0A, 5'h04, 5'h04};
         6'd32: bits = {5'h11, 5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
         6'd33: bits = {5'h11, 5'h0A, 5'h0A, 5'h04, 5'h0A, 5'h0A, 5'h11, 5'h11};
         6'd34: bits = {5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
         6'd35: bits = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10, 5'h1F};
         6'd36: bits = {5'h00, 5'h00, 5'h0E, 5'h01, 5'h0F, 5'h11, 5'h11, 5'h0F};
         6'd37: bits = {5'h10, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E};
         6'd38: bits = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h10, 5'h10, 5'h11, 5'h0E};
         6'd39: bits = {5'h01, 5'h01, 5'h01, 5'h0F, 5'h11, 5'h11, 5'h11, 5'h0F};
         6'd40: bits = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h1F, 5'h10, 5'h11, 5'h0E};
         6'd41: bits = {5'h03, 5'h04, 5'h04, 5'h0E, 5'h04, 5'h04, 5'h04, 5'h04};
         6'd42: bits = {5'h00, 5'h00, 5'h0F, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h0E};
         6'd43: bits = {5'h10, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h11};
         6'd44: bits = {5'h00, 5'h04, 5'h00, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h0E};
         6'd45: bits = {5'h02, 5'h00, 5'h06, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C};
         6'd46: bits = {5'h10, 5'h10, 5'h11, 5'h12, 5'h1C, 5'h14, 5'h12, 5'h11};
         6'd47: bits = {5'h18, 5'h08, 5'h08, 5'h08, 5'h08, 5'h08, 5'h08, 5'h07};
         6'd48: bits = {5'h00, 5'h00, 5'h1E, 5'h15, 5'h15, 5'h15, 5'h15, 5'h15};
         6'd49: bits = {5'h00, 5'h00, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11};
         6'd50: bits = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
         6'd51: bits = {5'h00, 5'h00, 5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10};
         6'd52: bits = {5'h00, 5'h00, 5'h0F, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01};
         6'd53: bits = {5'h00, 5'h00, 5'h16, 5'h18, 5'h10, 5'h10, 5'h10, 5'h10};
         6'd54: bits = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h08, 5'h06, 5'h11, 5'h0E};
         6'd55: bits = {5'h00, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h03};
         6'd56: bits = {5'h00, 5'h00, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0F};
         6'd57: bits = {5'h00, 5'h00, 5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04, 5'h04};
         6'd58: bits = {5'h00, 5'h00, 5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h0A};
         6'd59: bits = {5'h00, 5'h00, 5'h00, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11};
         6'd60: bits = {5'h00, 5'h00, 5'h11, 5'h11, 5'h0A, 5'h04, 5'h08, 5'h10};
         6'd61: bits = {5'h00, 5'h00, 5'h1F, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
         default: bits = '0;
      endcase
      return bits;
   endfunction

endpackage

`default_nettype wire

FILE: src/fgsr_req_if.sv
// Request channel: one character word with its glyph origin.
`default_nettype none

interface fgsr_req_if import fgsr_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [CHAR_W-1:0]            char_code;
   logic signed [ORIGIN_X_W-1:0] origin_x;
   logic signed [ORIGIN_Y_W-1:0] origin_y;

   modport source (output valid, char_code, origin_x, origin_y, input ready);
   modport sink   (input valid, char_code, origin_x, origin_y, output ready);
endinterface

`default_nettype wire

FILE: src/fgsr_rsp_if.sv
// Response channel: one glyph cell word.
`default_nettype none

interface fgsr_rsp_if import fgsr_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     write_enable;
   logic [PIXEL_INDEX_W-1:0] pixel_index;
   logic [COLOR_W-1:0]       pixel_color;
   logic                     unsupported;
   logic                     last;

   modport source (output valid, write_enable, pixel_index, pixel_color, unsupported, last,
                   input ready);
   modport sink   (input valid, write_enable, pixel_index, pixel_color, unsupported, last,
                   output ready);
endinterface

`default_nettype wire

FILE: src/fgsr_ctrl.sv
// Sequencer state machine: accepts a character and steps through its glyph cells.
`default_nettype none

module fgsr_ctrl import fgsr_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output fgsr_cmd_type         cmd,
   input  wire fgsr_status_type status
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff;
   logic state_in;

   // Take a new word only between characters
   assign req_ready = (state_ff == ST_IDLE);

   // Issue commands and pick the next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (status.out_free) begin
               if (status.unsup) begin
                  cmd.emit_err = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  cmd.step = 1'b1;
                  if (status.last_cell) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/fgsr_datapath.sv
// Datapath: captured glyph, cell counters, matrix addressing and output register.
`default_nettype none

module fgsr_datapath import fgsr_pkg::*; #(
   parameter int MATRIX_HEIGHT = 8,
   parameter int MATRIX_WIDTH  = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire fgsr_cmd_type                 cmd,
   output fgsr_status_type                   status,
   input  wire logic [CHAR_W-1:0]            req_char_code,
   input  wire logic signed [ORIGIN_X_W-1:0] req_origin_x,
   input  wire logic signed [ORIGIN_Y_W-1:0] req_origin_y,
   input  wire logic                         csr_we,
   input  wire logic [COLOR_W-1:0]           csr_wdata,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_write_enable,
   output logic [PIXEL_INDEX_W-1:0]          rsp_pixel_index,
   output logic [COLOR_W-1:0]                rsp_pixel_color,
   output logic                              rsp_unsupported,
   output logic                              rsp_last
);

   localparam int AREA_W = $clog2(MATRIX_WIDTH * MATRIX_HEIGHT);
   localparam int PROD_W = (AREA_W > PIXEL_INDEX_W) ? AREA_W : PIXEL_INDEX_W;

   // Captured item
   logic [GLYPH_BITS-1:0] glyph_ff,  glyph_in;
   logic                  unsup_ff,  unsup_in;
   logic [ORIGIN_X_W-1:0] ox_ff,     ox_in;
   logic [ORIGIN_Y_W-1:0] oy_ff,     oy_in;
   logic [COL_W-1:0]      col_ff,    col_in;
   logic [ROW_W-1:0]      row_ff,    row_in;
   logic [COLOR_W-1:0]    color_ff,  color_in;

   // Output register
   logic                     out_valid_ff, out_valid_in;
   logic                     out_we_ff,    out_we_in;
   logic [PIXEL_INDEX_W-1:0] out_idx_ff,   out_idx_in;
   logic [COLOR_W-1:0]       out_color_ff, out_color_in;
   logic                     out_unsup_ff, out_unsup_in;
   logic                     out_last_ff,  out_last_in;

   glyph_sel_type         sel;
   logic                  last_col;
   logic [POS_W-1:0]      x_pos;
   logic [POS_W-1:0]      y_pos;
   logic                  x_on;
   logic                  y_on;
   logic                  lit;
   logic                  cell_we;
   logic [PROD_W-1:0]     x_base;
   logic [PROD_W-1:0]     y_off;
   logic [PROD_W-1:0]     idx_full;

   assign sel      = glyph_of(req_char_code);
   assign last_col = (col_ff == COL_W'(GLYPH_W - 1));

   // Capture the word, then advance one cell per step
   always_comb begin
      glyph_in = glyph_ff;
      unsup_in = unsup_ff;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      if (cmd.load) begin
         glyph_in = font_glyph(sel.idx);
         unsup_in = !sel.ok;
         ox_in    = req_origin_x;
         oy_in    = req_origin_y;
         col_in   = '0;
         row_in   = '0;
      end else if (cmd.step) begin
         glyph_in = {glyph_ff[GLYPH_BITS-2:0], 1'b0};
         if (last_col) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // Matrix position of the current cell
   assign x_pos = {{(POS_W - ORIGIN_X_W){ox_ff[ORIGIN_X_W-1]}}, ox_ff}
                + {{(POS_W - COL_W){1'b0}}, col_ff};
   assign y_pos = {{(POS_W - ORIGIN_Y_W){oy_ff[ORIGIN_Y_W-1]}}, oy_ff}
                + {{(POS_W - ROW_W){1'b0}}, row_ff};
   assign x_on  = !x_pos[POS_W-1] && ({1'b0, x_pos[POS_W-2:0]} < POS_W'(MATRIX_WIDTH));
   assign y_on  = !y_pos[POS_W-1] && ({1'b0, y_pos[POS_W-2:0]} < POS_W'(MATRIX_HEIGHT));
   assign lit   = glyph_ff[GLYPH_BITS-1];
   assign cell_we = lit && x_on && y_on;

   // Serpentine column-major index; odd columns run bottom to top
   assign x_base = PROD_W'(x_pos[POS_W-2:0]) * PROD_W'(MATRIX_HEIGHT);
   assign y_off  = x_pos[0] ? (PROD_W'(MATRIX_HEIGHT - 1) - PROD_W'(y_pos[POS_W-2:0]))
                            : PROD_W'(y_pos[POS_W-2:0]);
   assign idx_full = x_base + y_off;

   // Load the output register on a step or error, drop it once taken
   always_comb begin
      out_valid_in = out_valid_ff;
      out_we_in    = out_we_ff;
      out_idx_in   = out_idx_ff;
      out_color_in = out_color_ff;
      out_unsup_in = out_unsup_ff;
      out_last_in  = out_last_ff;
      if (cmd.step) begin
         out_valid_in = 1'b1;
         out_we_in    = cell_we;
         out_idx_in   = cell_we ? idx_full[PIXEL_INDEX_W-1:0] : '0;
         out_color_in = color_ff;
         out_unsup_in = 1'b0;
         out_last_in  = last_col && (row_ff == ROW_W'(GLYPH_H - 1));
      end else if (cmd.emit_err) begin
         out_valid_in = 1'b1;
         out_we_in    = 1'b0;
         out_idx_in   = '0;
         out_color_in = '0;
         out_unsup_in = 1'b1;
         out_last_in  = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Hold the draw color
   assign color_in = csr_we ? csr_wdata : color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         color_ff     <= COLOR_RESET;
      end else begin
         out_valid_ff <= out_valid_in;
         color_ff     <= color_in;
      end
   end

   always_ff @(posedge clock) begin
      glyph_ff     <= glyph_in;
      unsup_ff     <= unsup_in;
      ox_ff        <= ox_in;
      oy_ff        <= oy_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      out_we_ff    <= out_we_in;
      out_idx_ff   <= out_idx_in;
      out_color_ff <= out_color_in;
      out_unsup_ff <= out_unsup_in;
      out_last_ff  <= out_last_in;
   end

   assign status.last_cell = last_col && (row_ff == ROW_W'(GLYPH_H - 1));
   assign status.unsup     = unsup_ff;
   assign status.out_free  = !out_valid_ff || rsp_ready;

   assign rsp_valid        = out_valid_ff;
   assign rsp_write_enable = out_we_ff;
   assign rsp_pixel_index  = out_idx_ff;
   assign rsp_pixel_color  = out_color_ff;
   assign rsp_unsupported  = out_unsup_ff;
   assign rsp_last         = out_last_ff;

endmodule

`default_nettype wire

FILE: src/font_glyph_serpentine_rasterizer.sv
// Top level of the 5x8 glyph rasterizer for a serpentine LED matrix.
`default_nettype none

// Draws one character at a time. A request word carries a character code and a
// signed top-left origin; digits, upper-case and lower-case letters produce 40
// response words, one per glyph cell, rows top to bottom and columns left to
// right, with last set on the fortieth. Any other code produces a single word
// with unsupported and last set. The font entry is read once when the word is
// accepted; the sequencer then emits one cell per clock while the response side
// is ready, and waits while the response side stalls, also before the error
// word of an unsupported code. A new request is taken
// once the last word of the previous character sits in the output register.
// write_enable marks lit cells on the MATRIX_WIDTH x MATRIX_HEIGHT matrix, and
// pixel_index is the column-major serpentine address (odd columns bottom to
// top), low 8 bits. csr_wdata sets the 24-bit draw color; write it only while
// idle, as the block itself does not enforce this. It resets to white.
module font_glyph_serpentine_rasterizer import fgsr_pkg::*; #(
   parameter int MATRIX_HEIGHT = 8,
   parameter int MATRIX_WIDTH  = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   fgsr_req_if.sink                req_ch,
   fgsr_rsp_if.source              rsp_ch,
   input  wire logic               csr_we,
   input  wire logic [COLOR_W-1:0] csr_wdata
);

   fgsr_cmd_type    cmd;
   fgsr_status_type status;

   fgsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   fgsr_datapath #(
      .MATRIX_HEIGHT (MATRIX_HEIGHT),
      .MATRIX_WIDTH  (MATRIX_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_char_code    (req_ch.char_code),
      .req_origin_x     (req_ch.origin_x),
      .req_origin_y     (req_ch.origin_y),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_write_enable (rsp_ch.write_enable),
      .rsp_pixel_index  (rsp_ch.pixel_index),
      .rsp_pixel_color  (rsp_ch.pixel_color),
      .rsp_unsupported  (rsp_ch.unsupported),
      .rsp_last         (rsp_ch.last)
   );

   // An accepted word blocks a new word in the cycle after it
   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request accepted twice in a row");

   // Error word is alone and never writes
   a_err_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.unsupported) |-> (rsp_ch.last && !rsp_ch.write_enable))
      else $error("unsupported word malformed");

   // Sequencer only emits into a free output register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.step || cmd.emit_err) |-> status.out_free)
      else $error("output register overwritten");

   // Commands never overlap
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("conflicting datapath commands");

endmodule

`default_nettype wire
